/* rtl/core/spbo_pkg.sv */
package spbo_pkg;

  localparam int MAX_CELLS  = 64;
  localparam int COORD_BITS = 32;

  localparam int CAP   = (MAX_CELLS > 64) ? 64 : MAX_CELLS;
  localparam int IDX_W = $clog2(CAP);
  localparam int CNT_W = $clog2(CAP + 1);
  localparam int TOL_W = 16;
  localparam int SUM_W = ((COORD_BITS > TOL_W) ? COORD_BITS : TOL_W) + 2;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [TOL_W-1:0]             tol_t;
  typedef logic [CAP-1:0]               mask_t;
  typedef logic [IDX_W-1:0]             idx_t;
  typedef logic [CNT_W-1:0]             cnt_t;

  typedef struct packed {
    coord_t lx;
    coord_t ly;
    coord_t lz;
    coord_t hx;
    coord_t hy;
    coord_t hz;
  } box_t;

  // copy of a box that circulates around the ring during the compare
  typedef struct packed {
    box_t box;
    idx_t idx;
    logic vld;
  } travel_t;

  typedef struct packed {
    logic init;
    logic shift;
    logic cmp;
    logic pop;
    logic clear;
  } cell_cmd_t;

  // sign-extend a 32-bit corner, then wrap to COORD_BITS
  function automatic coord_t to_coord(logic signed [31:0] v);
    logic signed [63:0] w;
    w = 64'(v);
    return coord_t'(w[COORD_BITS-1:0]);
  endfunction

  // x <= y + t, exact
  function automatic logic le_slack(coord_t x, coord_t y, tol_t t);
    logic signed [SUM_W-1:0] lim;
    lim = SUM_W'(y) + $signed(SUM_W'({1'b0, t}));
    return SUM_W'(x) <= lim;
  endfunction

  function automatic logic boxes_overlap(box_t a, box_t b, tol_t t);
    logic ox;
    logic oy;
    logic oz;
    ox = (a.lx <= b.hx) && (b.lx <= a.hx);
    oy = le_slack(b.ly, a.hy, t) && le_slack(a.ly, b.hy, t);
    oz = le_slack(b.lz, a.hz, t) && le_slack(a.lz, b.hz, t);
    return ox && oy && oz;
  endfunction

endpackage

/* rtl/core/sweep_prune_box_overlap_core.sv */
// Boxes load one per cycle into a row of cells; tready stays high while loading.
// The transfer marked tlast starts a compare: each box copy
// rotates once around the cell ring, one pair test per cell per cycle.
// Results follow at one per cycle from the output register unless m_axis_tready is low;
// input is held off until the last one is registered.
// Reset clears count, flags, state and tolerance; stored boxes are not cleared.
module sweep_prune_box_overlap_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [15:0]  cfg_data_i,   // tolerance
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // low_x, low_y, low_z, high_x, high_y, high_z
  input  logic [191:0] s_axis_tdata,
  input  logic         s_axis_tlast, // last_box
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // box_index[5:0], overlap_mask[69:6], zero pad
  output logic [71:0]  m_axis_tdata,
  output logic         m_axis_tuser, // dropped
  output logic         m_axis_tlast  // final_mask
);
  import spbo_pkg::*;

  localparam logic [1:0] ST_LOAD = 2'd0;
  localparam logic [1:0] ST_CMP  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0] state_q, state_d;
  cnt_t       cnt_q, cnt_d;
  cnt_t       k_q, k_d;
  cnt_t       e_q, e_d;
  logic       ovf_q, ovf_d;
  tol_t       tol_q;

  logic       out_valid_q, out_valid_d;
  logic [5:0] out_idx_q;
  mask_t      out_mask_q;
  logic       out_drop_q;
  logic       out_last_q;

  logic       in_xfer;
  logic       kept;
  logic       pop;
  logic       done;
  cell_cmd_t  cmd;
  box_t       in_box;
  logic [CAP-1:0] load_sel;

  travel_t    trav [CAP];
  mask_t      masks [CAP];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= '0;
    end else if (cfg_valid_i) begin
      tol_q <= cfg_data_i;
    end
  end

  assign s_axis_tready = (state_q == ST_LOAD);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign kept          = cnt_q < cnt_t'(CAP);

  assign in_box = '{lx: to_coord(s_axis_tdata[31:0]),
                    ly: to_coord(s_axis_tdata[63:32]),
                    lz: to_coord(s_axis_tdata[95:64]),
                    hx: to_coord(s_axis_tdata[127:96]),
                    hy: to_coord(s_axis_tdata[159:128]),
                    hz: to_coord(s_axis_tdata[191:160])};

  assign pop  = (state_q == ST_EMIT) && (!out_valid_q || m_axis_tready) && (e_q < cnt_q);
  assign done = pop && ((e_q + cnt_t'(1)) == cnt_q);

  always_comb begin
    cmd.init  = (state_q == ST_CMP) && (k_q == '0);
    cmd.shift = (state_q == ST_CMP) && (k_q != '0) && (k_q < cnt_t'(CAP));
    cmd.cmp   = (state_q == ST_CMP) && (k_q > cnt_t'(1));
    cmd.pop   = pop;
    cmd.clear = done;
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    k_d         = k_q;
    e_d         = e_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_LOAD: begin
        if (in_xfer) begin
          if (kept) begin
            cnt_d = cnt_q + cnt_t'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (s_axis_tlast) begin
            state_d = ST_CMP;
            k_d     = '0;
          end
        end
      end
      ST_CMP: begin
        k_d = k_q + cnt_t'(1);
        if (k_q == cnt_t'(CAP)) begin
          state_d = ST_EMIT;
          e_d     = '0;
        end
      end
      ST_EMIT: begin
        if (pop) begin
          out_valid_d = 1'b1;
          e_d         = e_q + cnt_t'(1);
        end
        if (done) begin
          state_d = ST_LOAD;
          cnt_d   = '0;
          ovf_d   = 1'b0;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      cnt_q       <= '0;
      k_q         <= '0;
      e_q         <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      k_q         <= k_d;
      e_q         <= e_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_idx_q  <= 6'(e_q);
      out_mask_q <= masks[0];
      out_drop_q <= ovf_q;
      out_last_q <= (e_q + cnt_t'(1)) == cnt_q;
    end
  end

  for (genvar c = 0; c < CAP; c++) begin : g_cell
    assign load_sel[c] = in_xfer && kept && (cnt_q == cnt_t'(c));

    spbo_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .cmd_i    (cmd),
      .load_i   (load_sel[c]),
      .box_i    (in_box),
      .tol_i    (tol_q),
      .idx_i    (idx_t'(c)),
      .travel_i (trav[(c + CAP - 1) % CAP]),
      .travel_o (trav[c]),
      .mask_i   ((c == CAP - 1) ? mask_t'(0) : masks[(c + 1) % CAP]),
      .mask_o   (masks[c])
    );
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, 64'(out_mask_q), out_idx_q};
  assign m_axis_tuser  = out_drop_q;
  assign m_axis_tlast  = out_last_q;

  a_cnt_cap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= cnt_t'(CAP))
    else $error("box count above capacity");

  a_last_starts_cmp : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && s_axis_tlast |=> state_q == ST_CMP && cnt_q != '0)
    else $error("last box did not start a compare");

  a_done_reload : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |=> state_q == ST_LOAD && cnt_q == '0 && !ovf_q && m_axis_tvalid && m_axis_tlast)
    else $error("set not closed after final mask");

  a_one_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(load_sel))
    else $error("box loaded into more than one cell");

endmodule

/* rtl/core/spbo_cell.sv */
module spbo_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  spbo_pkg::cell_cmd_t cmd_i,
  input  logic                load_i,
  input  spbo_pkg::box_t      box_i,
  input  spbo_pkg::tol_t      tol_i,
  input  spbo_pkg::idx_t      idx_i,
  input  spbo_pkg::travel_t   travel_i,
  output spbo_pkg::travel_t   travel_o,
  input  spbo_pkg::mask_t     mask_i,
  output spbo_pkg::mask_t     mask_o
);
  import spbo_pkg::*;

  logic    valid_q;
  box_t    box_q;
  travel_t travel_q;
  mask_t   mask_q;
  mask_t   mask_d;
  logic    hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (cmd_i.clear) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end
  end

  assign hit = cmd_i.cmp && valid_q && travel_q.vld && boxes_overlap(box_q, travel_q.box, tol_i);

  always_comb begin
    mask_d = mask_q;
    if (cmd_i.init) begin
      mask_d = '0;
    end else if (cmd_i.pop) begin
      mask_d = mask_i;
    end else if (hit) begin
      mask_d[travel_q.idx] = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      box_q <= box_i;
    end
    if (cmd_i.init) begin
      travel_q <= '{box: box_q, idx: idx_i, vld: valid_q};
    end else if (cmd_i.shift) begin
      travel_q <= travel_i;
    end
    mask_q <= mask_d;
  end

  assign travel_o = travel_q;
  assign mask_o   = mask_q;

endmodule

/* sim/tb.sv */
typedef struct packed {
  logic signed [31:0] lx;
  logic signed [31:0] ly;
  logic signed [31:0] lz;
  logic signed [31:0] hx;
  logic signed [31:0] hy;
  logic signed [31:0] hz;
} box_in_t;

typedef struct {
  longint lx;
  longint ly;
  longint lz;
  longint hx;
  longint hy;
  longint hz;
} held_box_t;

typedef struct {
  bit [5:0]  index;
  bit [63:0] mask;
  bit        dropped;
  bit        last_box;
} mask_result_t;

class overlap_scoreboard;
  held_box_t    held [64];
  int unsigned  held_count;
  bit           overflow;
  bit [15:0]    tolerance;
  mask_result_t awaited_masks [$];
  int           errors;

  function void set_tolerance(bit [15:0] t);
    tolerance = t;
  endfunction

  function int remaining();
    return awaited_masks.size();
  endfunction

  function longint wrap_coord(logic signed [31:0] v);
    longint w;
    w = v;
    w = (w <<< (64 - spbo_pkg::COORD_BITS)) >>> (64 - spbo_pkg::COORD_BITS);
    return w;
  endfunction

  // x <= y + tolerance, no overflow
  function bit within_slack(longint x, longint y);
    logic signed [65:0] xs;
    logic signed [65:0] ys;
    xs = x;
    ys = y;
    return xs <= ys + $signed({50'd0, tolerance});
  endfunction

  function bit boxes_meet(held_box_t a, held_box_t b);
    if (!(a.lx <= b.hx && b.lx <= a.hx)) return 1'b0;
    if (!(within_slack(b.ly, a.hy) && within_slack(a.ly, b.hy))) return 1'b0;
    return within_slack(b.lz, a.hz) && within_slack(a.lz, b.hz);
  endfunction

  function void note_box(box_in_t b, bit last);
    bit [63:0] masks [64];
    int n;
    mask_result_t entry;
    if (held_count < spbo_pkg::CAP) begin
      held[held_count] = '{wrap_coord(b.lx), wrap_coord(b.ly), wrap_coord(b.lz),
                           wrap_coord(b.hx), wrap_coord(b.hy), wrap_coord(b.hz)};
      held_count++;
    end else begin
      overflow = 1'b1;
    end
    if (!last) return;
    n = held_count;
    for (int i = 0; i < 64; i++) masks[i] = '0;
    for (int i = 0; i < n; i++) begin
      for (int j = i + 1; j < n; j++) begin
        if (boxes_meet(held[i], held[j])) begin
          masks[i][j] = 1'b1;
          masks[j][i] = 1'b1;
        end
      end
    end
    for (int i = 0; i < n; i++) begin
      entry = '{6'(i), masks[i], overflow, i == n - 1};
      awaited_masks.insert(awaited_masks.size(), entry);
    end
    held_count = 0;
    overflow = 1'b0;
  endfunction

  function void check_mask(logic [71:0] data, logic user, logic last);
    mask_result_t want;
    if (awaited_masks.size() == 0) begin
      $error("unexpected result transfer: box_index %0d", data[5:0]);
      errors++;
      return;
    end
    want = awaited_masks.pop_front();
    if (data[5:0] !== want.index) begin
      $error("box_index: expected %0d, got %0d", want.index, data[5:0]);
      errors++;
    end
    if (data[69:6] !== want.mask) begin
      $error("overlap_mask: expected %h, got %h", want.mask, data[69:6]);
      errors++;
    end
    if (user !== want.dropped) begin
      $error("dropped: expected %0b, got %0b", want.dropped, user);
      errors++;
    end
    if (last !== want.last_box) begin
      $error("final_mask: expected %0b, got %0b", want.last_box, last);
      errors++;
    end
  endfunction
endclass

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT    = 2000;
  localparam int SETTLE_CYCLES = spbo_pkg::CAP + 16;
  localparam int ITEM_TARGET   = 160;
  localparam int HOLD_CYCLES   = 300;
  localparam int COORD_MIN     = 32'sh8000_0000;
  localparam int COORD_MAX     = 32'sh7FFF_FFFF;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [15:0]  cfg_data = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [191:0] s_axis_tdata = '0;
  logic         s_axis_tlast = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [71:0]  m_axis_tdata;
  logic         m_axis_tuser;
  logic         m_axis_tlast;

  overlap_scoreboard sb = new();

  int        items_sent = 0;
  int        idle_cycles = 0;
  int        stall_left = 0;
  bit        hold_request = 1'b0;
  bit        no_idle = 1'b0;
  bit [15:0] cur_tol = '0;

  always #4 clk = ~clk;

  sweep_prune_box_overlap_core i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always @(posedge clk) begin
    if (rst_n && m_axis_tvalid && m_axis_tready) begin
      sb.check_mask(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("sweep_prune_box_overlap_core test failed");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // result side
  initial begin
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        m_axis_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (stall_left > 0) begin
        m_axis_tready = 1'b0;
        stall_left--;
      end else begin
        m_axis_tready = 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  task automatic send_box(box_in_t b, bit last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      s_axis_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_axis_tvalid = 1'b1;
    s_axis_tdata = {b.hz, b.hy, b.hx, b.lz, b.ly, b.lx};
    s_axis_tlast = last;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_box(b, last);
    items_sent++;
  endtask

  task automatic write_tolerance(bit [15:0] t);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data = t;
    do @(posedge clk); while (!cfg_ready);
    sb.set_tolerance(t);
    cur_tol = t;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic drain();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (sb.remaining() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic box_in_t mk_box(int lx, int ly, int lz, int hx, int hy, int hz);
    box_in_t b;
    b = '{lx, ly, lz, hx, hy, hz};
    return b;
  endfunction

  // touching in X, gaps of exactly tol and tol+1 in Y/Z, inverted box, extremes
  task automatic run_directed();
    int t;
    t = int'(cur_tol);
    send_box(mk_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX), 1'b1);
    send_box(mk_box(0, 0, 0, 100, 100, 100), 1'b0);
    send_box(mk_box(100, 100 + t, 0, 200, 200 + t, 100), 1'b0);
    send_box(mk_box(-100, 0, 101 + t, 0, 100, 300 + t), 1'b0);
    send_box(mk_box(150, 0, 0, 120, 100, 100), 1'b1);
    send_box(mk_box(COORD_MIN, COORD_MIN, COORD_MAX, -1, COORD_MIN, COORD_MAX), 1'b0);
    send_box(mk_box(-1, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MAX), 1'b0);
    send_box(mk_box(0, COORD_MAX, COORD_MIN, 0, COORD_MAX, COORD_MIN), 1'b1);
  endtask

  function automatic box_in_t make_box(box_in_t prev, bit has_prev, int base);
    logic signed [31:0] lo [3];
    logic signed [31:0] hi [3];
    logic signed [31:0] ph [3];
    logic signed [31:0] swap;
    int pick;
    box_in_t b;
    ph[0] = prev.hx;
    ph[1] = prev.hy;
    ph[2] = prev.hz;
    pick = $urandom_range(0, 9);
    for (int a = 0; a < 3; a++) begin
      if (pick == 0) begin
        lo[a] = $urandom;
        hi[a] = $urandom;
      end else begin
        if (has_prev && pick <= 3 && a == pick - 1) begin
          lo[a] = ph[a] + ((a == 0) ? 0 : int'(cur_tol)) + int'($urandom_range(0, 1));
        end else begin
          lo[a] = base + int'($urandom_range(0, 6000)) - 3000;
        end
        hi[a] = lo[a] + int'($urandom_range(0, 2500));
        if ($urandom_range(0, 15) == 0) begin
          swap = lo[a];
          lo[a] = hi[a];
          hi[a] = swap;
        end
      end
    end
    b = '{lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]};
    return b;
  endfunction

  task automatic send_random_set(int n);
    box_in_t prev;
    box_in_t b;
    int base;
    case ($urandom_range(0, 4))
      0, 1:    base = 0;
      2:       base = 2147470000;
      3:       base = -2147480000;
      default: base = int'($urandom_range(0, 32'h7FFF_FFFF)) - 32'sh4000_0000;
    endcase
    prev = '0;
    for (int k = 0; k < n; k++) begin
      b = make_box(prev, k > 0, base);
      send_box(b, k == n - 1);
      prev = b;
    end
  endtask

  initial begin
    int phase;
    int n;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    write_tolerance(16'd0);
    run_directed();
    drain();
    write_tolerance(16'hFFFF);
    run_directed();

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      drain();
      case (phase % 4)
        0:       write_tolerance(16'($urandom_range(0, 3000)));
        1:       write_tolerance(16'd1);
        2:       write_tolerance(16'($urandom_range(0, 65535)));
        default: write_tolerance(16'd0);
      endcase
      no_idle = (phase % 4 == 2);
      for (int s = 0; s < 4; s++) begin
        // one over-capacity set; the next set runs into a long output stall
        if (phase == 1 && s == 0) n = spbo_pkg::CAP + 2;
        else n = $urandom_range(1, 8);
        if (phase == 1 && s == 1) hold_request = 1'b1;
        send_random_set(n);
      end
      phase++;
    end

    drain();
    if (sb.errors == 0 && sb.remaining() == 0) begin
      $display("sweep_prune_box_overlap_core test passed");
    end else begin
      $display("sweep_prune_box_overlap_core test failed");
    end
    $finish;
  end
endmodule
